/* sv/cstg_pkg.sv */
// ----------------------------------------------------------------------------
// cstg_pkg: shared types and constants of the chunked sine tone generator
//
// Field widths, register indexes, reset values and the CORDIC arctangent
// table in binary-angle units.
// ----------------------------------------------------------------------------
package cstg_pkg;

    localparam int FREQ_W    = 20;
    localparam int LEN_W     = 32;
    localparam int CHUNK_W   = 7;
    localparam int IDX_W     = 6;
    localparam int ANGLE_W   = 32;
    localparam int CORDIC_W  = 34;
    localparam int CFG_W     = 32;
    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] REG_TONE_FREQ     = 2'd0;
    localparam logic [1:0] REG_SMP_RATE      = 2'd1;
    localparam logic [1:0] REG_STREAM_LENGTH = 2'd2;
    localparam logic [1:0] REG_CHUNK_LEN     = 2'd3;

    localparam logic [FREQ_W-1:0]  TONE_FREQ_RST     = 20'd0;
    localparam logic [FREQ_W-1:0]  SMP_RATE_RST      = 20'd48000;
    localparam logic [LEN_W-1:0]   STREAM_LENGTH_RST = 32'd0;
    localparam logic [CHUNK_W-1:0] CHUNK_LEN_RST     = 7'd64;

    // CORDIC gain compensation 0.60725 in Q4.30.
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

    // Status of an iterative unit: busy while stepping, done once the
    // result is held, until the next start.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // round(atan(2^-i) * 2^32 / (2*pi))
    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [4:0] idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* sv/chunked_sine_tone_generator.sv */
// ----------------------------------------------------------------------------
// chunked_sine_tone_generator: chunked sine tone source
//
// Each request word produces one chunk of sine samples from a phase
// accumulator through an iterative CORDIC unit.
// ----------------------------------------------------------------------------
// Each request word on the slave stream asks for the next chunk of up to
// the configured chunk length in samples (capped at CHUNK_MAX); restart in
// s_tdata bit 0 first clears the phase and reloads the stream length. The
// samples of a chunk come one after another from the single CORDIC unit,
// which does one micro-rotation per cycle for every sample. A restart first
// runs the bit-serial phase step division, and the sample stream holding
// tready low on a waiting word stalls the generator. The master stream
// carries the sample and its index, tlast on the final word of the chunk,
// and tuser flags for end of stream and the empty chunk. The next request is
// taken while the final word of the previous chunk still waits. Configuration
// is written over the APB port; the user must write it only while the block
// is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module chunked_sine_tone_generator
    import cstg_pkg::*;
#(
    parameter int CHUNK_MAX    = 64,
    parameter int PHASE_BITS   = 32,
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_ITERS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Request stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] restart
    // Sample stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((SAMPLE_BITS+IDX_W+7)/8)*8-1:0] m_tdata, // sample, sample_index
    output logic                  m_tlast,
    output logic [1:0]            m_tuser,   // [0] end_of_stream, [1] empty_res
    // Configuration.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]      pwdata,
    output logic [CFG_W-1:0]      prdata,
    output logic                  pready
);

    localparam int TDATA_W = ((SAMPLE_BITS + IDX_W + 7) / 8) * 8;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_PREP  = 6'b000100,
        ST_EMPTY = 6'b001000,
        ST_START = 6'b010000,
        ST_RUN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [FREQ_W-1:0]  tone_freq_reg;
    logic [FREQ_W-1:0]  smp_rate_reg;
    logic [LEN_W-1:0]   stream_length_reg;
    logic [CHUNK_W-1:0] chunk_len_reg;

    logic [PHASE_BITS-1:0] phase_acc_reg, phase_acc_next;
    logic [PHASE_BITS-1:0] phase_step_reg, phase_step_next;
    logic [LEN_W-1:0]      remaining_reg, remaining_next;
    logic [CHUNK_W-1:0]    n_reg, n_next;
    logic [CHUNK_W-1:0]    cnt_reg, cnt_next;
    logic                  eos_reg, eos_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic [IDX_W-1:0]              out_index_reg, out_index_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_eos_reg, out_eos_next;
    logic                          out_empty_reg, out_empty_next;

    logic                          div_start;
    logic [PHASE_BITS-1:0]         div_quot;
    unit_stat_t                    div_stat;
    logic                          cor_start;
    logic signed [SAMPLE_BITS-1:0] cor_sine;
    unit_stat_t                    cor_stat;

    logic               s_accept;
    logic               out_free;
    logic               cfg_write;
    logic [CHUNK_W-1:0] cs;
    logic [CHUNK_W-1:0] n_calc;
    logic [LEN_W-1:0]   rem_after;
    logic               last_sample;

    cstg_div #(
        .PHASE_BITS(PHASE_BITS)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .freq   (tone_freq_reg),
        .rate   (smp_rate_reg),
        .quot   (div_quot),
        .stat   (div_stat)
    );

    cstg_cordic #(
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CORDIC_ITERS(CORDIC_ITERS)
    ) u_cordic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cor_start),
        .phase  (phase_acc_reg),
        .sine   (cor_sine),
        .stat   (cor_stat)
    );

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_TONE_FREQ:     prdata = CFG_W'(tone_freq_reg);
            REG_SMP_RATE:      prdata = CFG_W'(smp_rate_reg);
            REG_STREAM_LENGTH: prdata = CFG_W'(stream_length_reg);
            REG_CHUNK_LEN:     prdata = CFG_W'(chunk_len_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_freq_reg     <= TONE_FREQ_RST;
            smp_rate_reg      <= SMP_RATE_RST;
            stream_length_reg <= STREAM_LENGTH_RST;
            chunk_len_reg     <= CHUNK_LEN_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_TONE_FREQ:     tone_freq_reg     <= pwdata[FREQ_W-1:0];
                REG_SMP_RATE:      smp_rate_reg      <= pwdata[FREQ_W-1:0];
                REG_STREAM_LENGTH: stream_length_reg <= pwdata[LEN_W-1:0];
                REG_CHUNK_LEN:     chunk_len_reg     <= pwdata[CHUNK_W-1:0];
                default: ;
            endcase
        end
    end

    // Chunk length: configured length capped at CHUNK_MAX, then at what remains.
    assign cs        = (chunk_len_reg > CHUNK_W'(CHUNK_MAX)) ? CHUNK_W'(CHUNK_MAX)
                                                             : chunk_len_reg;
    assign n_calc    = (LEN_W'(cs) < remaining_reg) ? cs : CHUNK_W'(remaining_reg);
    assign rem_after = remaining_reg - LEN_W'(n_calc);

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid & s_tready;
    assign out_free    = !out_valid_reg || m_tready;
    assign last_sample = ((cnt_reg + CHUNK_W'(1)) == n_reg);

    always_comb begin
        state_next      = state_reg;
        phase_acc_next  = phase_acc_reg;
        phase_step_next = phase_step_reg;
        remaining_next  = remaining_reg;
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        eos_next        = eos_reg;
        out_valid_next  = out_valid_reg & ~m_tready;
        out_sample_next = out_sample_reg;
        out_index_next  = out_index_reg;
        out_last_next   = out_last_reg;
        out_eos_next    = out_eos_reg;
        out_empty_next  = out_empty_reg;
        div_start       = 1'b0;
        cor_start       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tdata[0]) begin
                        phase_acc_next = '0;
                        remaining_next = stream_length_reg;
                        div_start      = 1'b1;
                        state_next     = ST_DIV;
                    end else begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    phase_step_next = div_quot;
                    state_next      = ST_PREP;
                end
            end
            ST_PREP: begin
                n_next         = n_calc;
                remaining_next = rem_after;
                eos_next       = (rem_after == '0);
                cnt_next       = '0;
                state_next     = (n_calc == '0) ? ST_EMPTY : ST_START;
            end
            ST_EMPTY: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_sample_next = '0;
                    out_index_next  = '0;
                    out_last_next   = 1'b1;
                    out_eos_next    = eos_reg;
                    out_empty_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_START: begin
                cor_start  = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (cor_stat.done && out_free) begin
                    out_valid_next  = 1'b1;
                    out_sample_next = cor_sine;
                    out_index_next  = cnt_reg[IDX_W-1:0];
                    out_last_next   = last_sample;
                    out_eos_next    = eos_reg;
                    out_empty_next  = 1'b0;
                    phase_acc_next  = phase_acc_reg + phase_step_reg;
                    cnt_next        = cnt_reg + CHUNK_W'(1);
                    state_next      = last_sample ? ST_IDLE : ST_START;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            remaining_reg  <= '0;
            n_reg          <= '0;
            cnt_reg        <= '0;
            eos_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
            remaining_reg  <= remaining_next;
            n_reg          <= n_next;
            cnt_reg        <= cnt_next;
            eos_reg        <= eos_next;
            out_valid_reg  <= out_valid_next;
        end
        out_sample_reg <= out_sample_next;
        out_index_reg  <= out_index_next;
        out_last_reg   <= out_last_next;
        out_eos_reg    <= out_eos_next;
        out_empty_reg  <= out_empty_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({out_index_reg, out_sample_reg});
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_empty_reg, out_eos_reg};

`ifndef SYNTHESIS
    // No request is taken while either arithmetic unit is still working.
    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(div_stat.busy || cor_stat.busy))
        else $error("request accepted while a unit is busy");

    // An empty chunk word is always the last one and carries a zero sample.
    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tlast && (out_sample_reg == '0)))
        else $error("empty word without tlast or with a sample");

    // While samples are produced the count stays below the chunk length.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RUN) || (state_reg == ST_START)) |-> (cnt_reg < n_reg))
        else $error("sample count beyond chunk length");

    // In the cycle after a request is taken, s_tready is low.
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("two requests in consecutive cycles");
`endif

endmodule

/* sv/cstg_div.sv */
// ----------------------------------------------------------------------------
// cstg_div: phase step divider
//
// Restoring long division of tone_freq * 2^PHASE_BITS by the sample rate, one
// quotient bit per cycle. Only the low PHASE_BITS quotient bits are kept.
// ----------------------------------------------------------------------------
module cstg_div
    import cstg_pkg::*;
#(
    parameter int PHASE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [FREQ_W-1:0]     freq,
    input  logic [FREQ_W-1:0]     rate,
    output logic [PHASE_BITS-1:0] quot,
    output unit_stat_t            stat
);

    localparam int STEPS = FREQ_W + PHASE_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [FREQ_W-1:0]     num_reg, num_next;
    logic [FREQ_W-1:0]     rem_reg, rem_next;
    logic [FREQ_W-1:0]     den_reg, den_next;
    logic [PHASE_BITS-1:0] q_reg, q_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  zero_reg, zero_next;

    logic [FREQ_W:0] trial;
    logic [FREQ_W:0] diff;
    logic            ge;

    assign trial = {rem_reg, num_reg[FREQ_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        zero_next = zero_reg;
        if (start) begin
            num_next  = freq;
            rem_next  = '0;
            den_next  = rate;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
            zero_next = (rate == '0);
        end else if (busy_reg) begin
            num_next = {num_reg[FREQ_W-2:0], 1'b0};
            rem_next = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
            q_next   = {q_reg[PHASE_BITS-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        zero_reg <= zero_next;
    end

    // A zero sample rate gives a zero step.
    assign quot      = zero_reg ? '0 : q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* sv/cstg_cordic.sv */
// ----------------------------------------------------------------------------
// cstg_cordic: iterative rotation-mode CORDIC sine
//
// Folds the phase into the right half plane, runs one micro-rotation per
// cycle, then rounds and saturates y to a Q1.(SAMPLE_BITS-1) sample.
// ----------------------------------------------------------------------------
module cstg_cordic
    import cstg_pkg::*;
#(
    parameter int PHASE_BITS   = 32,
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_ITERS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [PHASE_BITS-1:0]         phase,
    output logic signed [SAMPLE_BITS-1:0] sine,
    output unit_stat_t                    stat
);

    localparam int ITER_W = $clog2(CORDIC_ITERS);
    localparam int SH     = 31 - SAMPLE_BITS;
    localparam logic signed [CORDIC_W-1:0] RND = CORDIC_W'(64'd1 << (SH - 1));
    localparam logic signed [CORDIC_W-1:0] LIM =
        CORDIC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] angle_fold;
    logic               fold;

    if (PHASE_BITS <= ANGLE_W) begin : g_align_up
        assign angle = ANGLE_W'(64'(phase) << (ANGLE_W - PHASE_BITS));
    end else begin : g_align_down
        assign angle = ANGLE_W'(64'(phase) >> (PHASE_BITS - ANGLE_W));
    end

    // Second and third quadrants move by half a turn; bit 31 flips.
    assign fold       = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
    assign angle_fold = fold ? {~angle[ANGLE_W-1], angle[ANGLE_W-2:0]} : angle;

    logic signed [CORDIC_W-1:0]    x_reg, x_next;
    logic signed [CORDIC_W-1:0]    y_reg, y_next;
    logic signed [CORDIC_W-1:0]    z_reg, z_next;
    logic [ITER_W-1:0]             iter_reg, iter_next;
    logic                          neg_reg, neg_next;
    logic                          busy_reg, busy_next;
    logic                          fin_reg, fin_next;
    logic                          done_reg, done_next;
    logic signed [SAMPLE_BITS-1:0] res_reg, res_next;

    logic signed [CORDIC_W-1:0] dx, dy, da;
    logic signed [CORDIC_W-1:0] t_rnd, t_sat;

    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign da = $signed({2'b00, atan_turn(5'(iter_reg))});

    always_comb begin
        t_rnd = (y_reg + RND) >>> SH;
        if (t_rnd > LIM) begin
            t_sat = LIM;
        end else if (t_rnd < -LIM) begin
            t_sat = -LIM;
        end else begin
            t_sat = t_rnd;
        end
    end

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        iter_next = iter_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = done_reg;
        res_next  = res_reg;
        if (start) begin
            x_next    = CORDIC_X0;
            y_next    = '0;
            z_next    = $signed({{(CORDIC_W-ANGLE_W){angle_fold[ANGLE_W-1]}}, angle_fold});
            iter_next = '0;
            neg_next  = fold;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (!z_reg[CORDIC_W-1]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - da;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + da;
            end
            iter_next = iter_reg + ITER_W'(1);
            if (iter_reg == ITER_W'(CORDIC_ITERS - 1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            res_next  = SAMPLE_BITS'(neg_reg ? -t_sat : t_sat);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign sine      = res_reg;
    assign stat.busy = busy_reg | fin_reg;
    assign stat.done = done_reg;

endmodule
